FILE: rtl/core/mandelbrot_escape_time_pixel_top_defines.svh
// Assertion macros used by the escape-time pixel top level
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_TOP_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high
`define MBE_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high
`define MBE_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/mbe_pkg.sv
// Package: widths, reset values, register indexes and config struct
`timescale 1ns / 1ps

package mbe_pkg;

   localparam int WORD_W    = 32;
   localparam int FRAC_BITS = 28;
   localparam int MAX_DIM   = 4096;
   localparam int COORD_W   = $clog2(MAX_DIM);
   localparam int LIMIT_W   = 16;
   localparam int CSR_IDX_W = 3;
   localparam int PROD_W    = 2 * WORD_W;
   // a square shifted down by FRAC_BITS, sign included
   localparam int SQ_W      = PROD_W - FRAC_BITS;
   // room for the sum of two squares and for the escape bound
   localparam int SUM_W     = (SQ_W + 1 > FRAC_BITS + 4) ? SQ_W + 1 : FRAC_BITS + 4;

   localparam logic [WORD_W-1:0]  X_ORIGIN_RST = 32'hE000_0000;
   localparam logic [WORD_W-1:0]  Y_ORIGIN_RST = 32'hE800_0000;
   localparam logic [WORD_W-1:0]  STEP_RST     = 32'h0010_0000;
   localparam logic [LIMIT_W-1:0] LIMIT_RST    = 16'd100;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_ORIGIN = 3'd0,
      CSR_Y_ORIGIN = 3'd1,
      CSR_STEP_X   = 3'd2,
      CSR_STEP_Y   = 3'd3,
      CSR_LIMIT    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] x_origin;
      logic signed [WORD_W-1:0] y_origin;
      logic signed [WORD_W-1:0] step_x;
      logic signed [WORD_W-1:0] step_y;
      logic [LIMIT_W-1:0]       iteration_limit;
   } cfg_type;

endpackage

FILE: rtl/core/mandelbrot_escape_time_pixel_top.sv
// Top level of the escape-time pixel evaluator
`timescale 1ns / 1ps
`include "mandelbrot_escape_time_pixel_top_defines.svh"

// Escape-time pixel evaluator.
// req_* carries one pixel (column, row); it is taken when req_valid is high
// and req_stall is low. rsp_* returns one iteration count per pixel, taken
// when rsp_valid is high and rsp_stall is low. csr_* writes the origin, the
// steps and the iteration limit; write it only while no pixel is in flight.
// One signed 32x32 multiplier is shared by every product: two to build the
// point c, then three per z update (zr^2, zi^2, zr*zi). An accepted pixel
// passes S_CRE, S_CIM and S_LDCI to build c, then runs S_RR, S_II, S_CROSS
// and S_UPD once per update, leaving for S_FIN when S_RR finds the limit
// reached or S_CROSS finds |z|^2 above 4; the next pixel is taken the cycle
// after the result is loaded.
// The result sits in an output register, so a stalled receiver does not stop
// a new pixel from entering; only a second finished count waits for it.
// Reset (synchronous) returns the sequencer to idle, drops any pending
// result and restores the default view and a limit of 100.
module mandelbrot_escape_time_pixel_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [mbe_pkg::COORD_W-1:0]   req_column,
   input  logic [mbe_pkg::COORD_W-1:0]   req_row,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mbe_pkg::LIMIT_W-1:0]   rsp_iterations,
   input  logic                          csr_wr_en,
   input  logic [mbe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mbe_pkg::WORD_W-1:0]    csr_data
);

   mbe_pkg::cfg_type                  csr_cfg;
   logic signed [mbe_pkg::WORD_W-1:0] mul_a;
   logic signed [mbe_pkg::WORD_W-1:0] mul_b;
   logic signed [mbe_pkg::PROD_W-1:0] mul_prod;

   mbe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (csr_cfg)
   );

   mbe_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (mul_prod)
   );

   mbe_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .cfg            (csr_cfg),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_column     (req_column),
      .req_row        (req_row),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_iterations (rsp_iterations),
      .mul_a          (mul_a),
      .mul_b          (mul_b),
      .mul_prod       (mul_prod)
   );

   `MBE_ASSERT_IMP(a_count_capped, rsp_valid, rsp_iterations <= csr_cfg.iteration_limit, "iteration count above limit")
   `MBE_ASSERT_NXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "pixel accepted but block not busy")
   `MBE_ASSERT_IMP(a_result_from_busy, $rose(rsp_valid), $past(req_stall), "result appeared without a pixel in flight")

endmodule

FILE: rtl/core/mbe_csr.sv
// Configuration registers: origin, steps and iteration limit
`timescale 1ns / 1ps

module mbe_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [mbe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mbe_pkg::WORD_W-1:0]    csr_data,
   output mbe_pkg::cfg_type              cfg
);

   mbe_pkg::cfg_type cfg_ff;
   mbe_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            mbe_pkg::CSR_X_ORIGIN: cfg_in.x_origin = $signed(csr_data);
            mbe_pkg::CSR_Y_ORIGIN: cfg_in.y_origin = $signed(csr_data);
            mbe_pkg::CSR_STEP_X:   cfg_in.step_x   = $signed(csr_data);
            mbe_pkg::CSR_STEP_Y:   cfg_in.step_y   = $signed(csr_data);
            mbe_pkg::CSR_LIMIT:    cfg_in.iteration_limit = csr_data[mbe_pkg::LIMIT_W-1:0];
            default: ; // drop writes to unmapped indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_origin        <= $signed(mbe_pkg::X_ORIGIN_RST);
         cfg_ff.y_origin        <= $signed(mbe_pkg::Y_ORIGIN_RST);
         cfg_ff.step_x          <= $signed(mbe_pkg::STEP_RST);
         cfg_ff.step_y          <= $signed(mbe_pkg::STEP_RST);
         cfg_ff.iteration_limit <= mbe_pkg::LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/core/mbe_mul.sv
// Shared signed multiplier with registered full-width product
`timescale 1ns / 1ps

module mbe_mul (
   input  logic                               clock,
   input  logic signed [mbe_pkg::WORD_W-1:0]  mul_a,
   input  logic signed [mbe_pkg::WORD_W-1:0]  mul_b,
   output logic signed [mbe_pkg::PROD_W-1:0]  prod_ff
);

   logic signed [mbe_pkg::PROD_W-1:0] prod_in;

   assign prod_in = mbe_pkg::PROD_W'(mul_a) * mbe_pkg::PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

FILE: rtl/core/mbe_seq.sv
// Sequencer and datapath: point setup, z iteration, escape test, result register
`timescale 1ns / 1ps

module mbe_seq (
   input  logic                               clock,
   input  logic                               reset,
   input  mbe_pkg::cfg_type                   cfg,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [mbe_pkg::COORD_W-1:0]        req_column,
   input  logic [mbe_pkg::COORD_W-1:0]        req_row,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [mbe_pkg::LIMIT_W-1:0]        rsp_iterations,
   output logic signed [mbe_pkg::WORD_W-1:0]  mul_a,
   output logic signed [mbe_pkg::WORD_W-1:0]  mul_b,
   input  logic signed [mbe_pkg::PROD_W-1:0]  mul_prod
);

   localparam int WORD_W  = mbe_pkg::WORD_W;
   localparam int PROD_W  = mbe_pkg::PROD_W;
   localparam int SQ_W    = mbe_pkg::SQ_W;
   localparam int SUM_W   = mbe_pkg::SUM_W;
   localparam int LIMIT_W = mbe_pkg::LIMIT_W;
   localparam int COORD_W = mbe_pkg::COORD_W;
   localparam logic signed [SUM_W-1:0] BOUND = SUM_W'(4) <<< mbe_pkg::FRAC_BITS;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_CRE   = 9'b000000010,
      S_CIM   = 9'b000000100,
      S_LDCI  = 9'b000001000,
      S_RR    = 9'b000010000,
      S_II    = 9'b000100000,
      S_CROSS = 9'b001000000,
      S_UPD   = 9'b010000000,
      S_FIN   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [COORD_W-1:0]       col_ff, col_in;
   logic [COORD_W-1:0]       row_ff, row_in;
   logic signed [WORD_W-1:0] c_re_ff, c_re_in;
   logic signed [WORD_W-1:0] c_im_ff, c_im_in;
   logic signed [WORD_W-1:0] zr_ff, zr_in;
   logic signed [WORD_W-1:0] zi_ff, zi_in;
   logic signed [SQ_W-1:0]   r2_ff, r2_in;
   logic signed [SQ_W-1:0]   i2_ff, i2_in;
   logic [LIMIT_W-1:0]       count_ff, count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [LIMIT_W-1:0]       rsp_iter_ff, rsp_iter_in;

   logic signed [PROD_W-1:0] sq_full;
   logic signed [PROD_W-1:0] cross_full;
   logic signed [SQ_W-1:0]   sq_now;
   logic signed [SUM_W-1:0]  mag_sum;
   logic                     escape;
   logic                     out_free;

   assign sq_full    = mul_prod >>> mbe_pkg::FRAC_BITS;
   assign cross_full = mul_prod >>> (mbe_pkg::FRAC_BITS - 1);
   assign sq_now     = sq_full[SQ_W-1:0];
   assign mag_sum    = SUM_W'(r2_ff) + SUM_W'(sq_now);
   assign escape     = mag_sum > BOUND;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_CRE: begin
            mul_a = $signed(WORD_W'(col_ff));
            mul_b = cfg.step_x;
         end
         S_CIM: begin
            mul_a = $signed(WORD_W'(row_ff));
            mul_b = cfg.step_y;
         end
         S_RR: begin
            mul_a = zr_ff;
            mul_b = zr_ff;
         end
         S_II: begin
            mul_a = zi_ff;
            mul_b = zi_ff;
         end
         S_CROSS: begin
            mul_a = zr_ff;
            mul_b = zi_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      c_re_in      = c_re_ff;
      c_im_in      = c_im_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      r2_in        = r2_ff;
      i2_in        = i2_ff;
      count_in     = count_ff;
      rsp_iter_in  = rsp_iter_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               col_in   = req_column;
               row_in   = req_row;
               count_in = '0;
               state_in = S_CRE;
            end
         end
         S_CRE: state_in = S_CIM;
         S_CIM: begin
            c_re_in  = mul_prod[WORD_W-1:0] + cfg.x_origin;
            zr_in    = mul_prod[WORD_W-1:0] + cfg.x_origin;
            state_in = S_LDCI;
         end
         S_LDCI: begin
            c_im_in  = mul_prod[WORD_W-1:0] + cfg.y_origin;
            zi_in    = mul_prod[WORD_W-1:0] + cfg.y_origin;
            state_in = S_RR;
         end
         S_RR: begin
            // stop once the limit of updates is reached
            state_in = (count_ff < cfg.iteration_limit) ? S_II : S_FIN;
         end
         S_II: begin
            r2_in    = sq_now;
            state_in = S_CROSS;
         end
         S_CROSS: begin
            i2_in    = sq_now;
            state_in = escape ? S_FIN : S_UPD;
         end
         S_UPD: begin
            zi_in    = cross_full[WORD_W-1:0] + c_im_ff;
            zr_in    = WORD_W'(r2_ff) - WORD_W'(i2_ff) + c_re_ff;
            count_in = count_ff + LIMIT_W'(1);
            state_in = S_RR;
         end
         S_FIN: begin
            // hold until the result register can take the count
            if (out_free) begin
               rsp_iter_in  = count_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff      <= col_in;
      row_ff      <= row_in;
      c_re_ff     <= c_re_in;
      c_im_ff     <= c_im_in;
      zr_ff       <= zr_in;
      zi_ff       <= zi_in;
      r2_ff       <= r2_in;
      i2_ff       <= i2_in;
      count_ff    <= count_in;
      rsp_iter_ff <= rsp_iter_in;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_iterations = rsp_iter_ff;

endmodule

FILE: bench/tb_mandelbrot_escape_time_pixel_top.sv
// Self-checking bench: escape-time pixel evaluator against a fixed-point iteration predictor
`timescale 1ns / 1ps

module tb_mandelbrot_escape_time_pixel_top;

   localparam int     MAX_GAP       = 40;
   localparam int     PIXELS_WANTED = 1050;
   localparam int     REPORT_CAP    = 30;
   localparam longint ESCAPE_R2     = longint'(4) << mbe_pkg::FRAC_BITS;
   localparam logic [mbe_pkg::WORD_W-1:0] ONE = 32'd1 << mbe_pkg::FRAC_BITS;

   typedef struct packed {
      logic [mbe_pkg::COORD_W-1:0] column;
      logic [mbe_pkg::COORD_W-1:0] row;
   } pixel_type;

   typedef struct packed {
      pixel_type                   px;
      logic [mbe_pkg::LIMIT_W-1:0] count;
   } count_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [mbe_pkg::COORD_W-1:0]   req_column = '0;
   logic [mbe_pkg::COORD_W-1:0]   req_row = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [mbe_pkg::LIMIT_W-1:0]   rsp_iterations;
   logic                          csr_wr_en = 1'b0;
   mbe_pkg::csr_index_type        csr_index = mbe_pkg::CSR_X_ORIGIN;
   logic [mbe_pkg::WORD_W-1:0]    csr_data = '0;

   // view and limit as the block should hold them
   logic signed [mbe_pkg::WORD_W-1:0] view_x0 = mbe_pkg::X_ORIGIN_RST;
   logic signed [mbe_pkg::WORD_W-1:0] view_y0 = mbe_pkg::Y_ORIGIN_RST;
   logic signed [mbe_pkg::WORD_W-1:0] view_dx = mbe_pkg::STEP_RST;
   logic signed [mbe_pkg::WORD_W-1:0] view_dy = mbe_pkg::STEP_RST;
   logic [mbe_pkg::LIMIT_W-1:0]       iter_cap = mbe_pkg::LIMIT_RST;

   pixel_type    pending_pixels[$];
   count_type    expected_counts[$];
   pixel_type    next_pixel;
   count_type    want;
   bit           req_taken = 1'b0;
   bit           quiet = 1'b0;
   int unsigned  req_hold = 0;
   int unsigned  stall_run = 0;
   int unsigned  queued_n = 0;
   int unsigned  accepted_n = 0;
   int unsigned  checked_n = 0;
   int unsigned  cap_hits = 0;
   int unsigned  setting_n = 1;
   int unsigned  fail_n = 0;
   longint       cycle_n = 0;
   longint       cycle_budget = 50000;

   mandelbrot_escape_time_pixel_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_column     (req_column),
      .req_row        (req_row),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_iterations (rsp_iterations),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // number of z updates before |z|^2 exceeds 4, capped at the limit
   function automatic logic [mbe_pkg::LIMIT_W-1:0] escape_count(
         logic [mbe_pkg::COORD_W-1:0] column,
         logic [mbe_pkg::COORD_W-1:0] row);
      longint acc, r2, i2;
      logic signed [mbe_pkg::WORD_W-1:0] c_re, c_im, zr, zi;
      int n;
      bit gone;
      acc = longint'(view_x0) + longint'(column) * longint'(view_dx);
      c_re = acc[mbe_pkg::WORD_W-1:0];
      acc = longint'(view_y0) + longint'(row) * longint'(view_dy);
      c_im = acc[mbe_pkg::WORD_W-1:0];
      zr = c_re;
      zi = c_im;
      n = 0;
      gone = 1'b0;
      while (!gone && n < int'(iter_cap)) begin
         r2 = (longint'(zr) * longint'(zr)) >>> mbe_pkg::FRAC_BITS;
         i2 = (longint'(zi) * longint'(zi)) >>> mbe_pkg::FRAC_BITS;
         if (r2 + i2 > ESCAPE_R2) begin
            gone = 1'b1;
         end else begin
            acc = ((longint'(zr) * longint'(zi)) >>> (mbe_pkg::FRAC_BITS - 1))
                  + longint'(c_im);
            zi = acc[mbe_pkg::WORD_W-1:0];
            acc = r2 - i2 + longint'(c_re);
            zr = acc[mbe_pkg::WORD_W-1:0];
            n++;
         end
      end
      return n[mbe_pkg::LIMIT_W-1:0];
   endfunction

   // mostly short gaps, a few long ones, none in quiet phases
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(99);
      if (quiet || r < 50) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(MAX_GAP, 4);
   endfunction

   task automatic report_mismatch(string what);
      fail_n++;
      if (fail_n <= REPORT_CAP) $display("%0t ns: mismatch: %s", $time, what);
   endtask

   task automatic write_reg(mbe_pkg::csr_index_type idx, logic [mbe_pkg::WORD_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      case (idx)
         mbe_pkg::CSR_X_ORIGIN: view_x0 = data;
         mbe_pkg::CSR_Y_ORIGIN: view_y0 = data;
         mbe_pkg::CSR_STEP_X:   view_dx = data;
         mbe_pkg::CSR_STEP_Y:   view_dy = data;
         mbe_pkg::CSR_LIMIT:    iter_cap = data[mbe_pkg::LIMIT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_view(logic [mbe_pkg::WORD_W-1:0] x0, logic [mbe_pkg::WORD_W-1:0] y0,
                           logic [mbe_pkg::WORD_W-1:0] dx, logic [mbe_pkg::WORD_W-1:0] dy,
                           logic [mbe_pkg::WORD_W-1:0] lim_word);
      write_reg(mbe_pkg::CSR_X_ORIGIN, x0);
      write_reg(mbe_pkg::CSR_Y_ORIGIN, y0);
      write_reg(mbe_pkg::CSR_STEP_X, dx);
      write_reg(mbe_pkg::CSR_STEP_Y, dy);
      write_reg(mbe_pkg::CSR_LIMIT, lim_word);
      setting_n++;
      quiet = ($urandom_range(3) == 0);
   endtask

   task automatic queue_pixel(logic [mbe_pkg::COORD_W-1:0] column,
                              logic [mbe_pkg::COORD_W-1:0] row);
      pending_pixels.push_back('{column: column, row: row});
      queued_n++;
      cycle_budget += 4 * (4 * longint'(iter_cap) + 7 + 2 * MAX_GAP + 8);
   endtask

   task automatic wait_drained();
      while (accepted_n != queued_n || expected_counts.size() != 0) @(negedge clock);
   endtask

   // a view over the set most of the time, wild registers otherwise
   task automatic random_view();
      int unsigned pick;
      logic [mbe_pkg::WORD_W-1:0] x0, y0, dx, dy;
      logic [mbe_pkg::LIMIT_W-1:0] lim, junk;
      pick = $urandom_range(99);
      if (pick < 70) begin
         x0 = $urandom_range(939524096) - 671088640;
         y0 = $urandom_range(805306368) - 402653184;
         dx = (32'd1 << $urandom_range(18, 8)) + $urandom_range(255);
         dy = (32'd1 << $urandom_range(18, 8)) + $urandom_range(255);
         if ($urandom_range(1)) dx = -dx;
         if ($urandom_range(1)) dy = -dy;
      end else begin
         x0 = $urandom;
         y0 = $urandom;
         dx = $urandom;
         dy = $urandom;
      end
      pick = $urandom_range(99);
      if (pick < 60)      lim = $urandom_range(32, 1);
      else if (pick < 85) lim = $urandom_range(128, 33);
      else if (pick < 97) lim = $urandom_range(300, 129);
      else                lim = '0;
      junk = $urandom;
      set_view(x0, y0, dx, dy, {junk, lim});
   endtask

   // request side: hold a stalled item, else gap or present the next one
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_hold != 0) begin
            req_hold--;
            req_valid <= 1'b0;
         end else if (pending_pixels.size() != 0) begin
            next_pixel = pending_pixels.pop_front();
            req_valid  <= 1'b1;
            req_column <= next_pixel.column;
            req_row    <= next_pixel.row;
            req_hold   = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      if (!reset && stall_run == 0 && !quiet && $urandom_range(3) == 0)
         stall_run = pick_gap();
      if (stall_run != 0) begin
         stall_run--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycle_n++;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            accepted_n++;
            expected_counts.push_back('{px: '{column: req_column, row: req_row},
                                        count: escape_count(req_column, req_row)});
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_counts.size() == 0) begin
               report_mismatch($sformatf("count %0d with no pixel outstanding",
                                         rsp_iterations));
            end else begin
               want = expected_counts.pop_front();
               checked_n++;
               if (want.count == iter_cap) cap_hits++;
               if (rsp_iterations !== want.count)
                  report_mismatch($sformatf("pixel (%0d,%0d): iterations %0d, predicted %0d",
                                            want.px.column, want.px.row,
                                            rsp_iterations, want.count));
            end
         end
      end
      if (cycle_n > cycle_budget) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_n, expected_counts.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      logic [mbe_pkg::LIMIT_W-1:0] junk;
      int unsigned n;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset view: corners, points in the set, the boundary at c = 2 and c = -2
      queue_pixel(0, 0);
      queue_pixel(4095, 4095);
      queue_pixel(4095, 0);
      queue_pixel(0, 4095);
      queue_pixel(512, 384);
      queue_pixel(256, 384);
      queue_pixel(576, 384);
      queue_pixel(1024, 384);
      queue_pixel(0, 384);
      queue_pixel(512, 640);
      queue_pixel(448, 480);
      queue_pixel(2730, 1365);
      wait_drained();

      // extreme registers: the point c wraps around 32 bits
      set_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0001);
      queue_pixel(0, 0);
      queue_pixel(1, 1);
      queue_pixel(4095, 4095);
      queue_pixel(2, 3);
      wait_drained();

      // limit of zero, then writes to unused indexes must change nothing
      junk = $urandom;
      set_view('0, '0, '0, '0, {junk, 16'h0000});
      for (int k = 1; k <= 3; k++)
         write_reg(mbe_pkg::csr_index_type'(mbe_pkg::CSR_LIMIT + k), $urandom);
      queue_pixel(0, 0);
      queue_pixel(4095, 4095);
      wait_drained();

      // largest limit: the origin never escapes, the wrapped far corner lands on -1 - i
      set_view('0, '0, ONE, ONE, 32'hFFFF_FFFF);
      queue_pixel(0, 0);
      queue_pixel(3, 0);
      queue_pixel(1, 1);
      queue_pixel(4095, 4095);
      wait_drained();

      while (queued_n < PIXELS_WANTED) begin
         random_view();
         n = $urandom_range(80, 20);
         repeat (n) queue_pixel($urandom_range(4095), $urandom_range(4095));
         wait_drained();
      end

      repeat (4 * int'(iter_cap) + 16) @(negedge clock);
      $display("%0d pixels checked over %0d view/limit settings, limits from 0 to 65535",
               checked_n, setting_n);
      $display("%0d counts ran to the limit, %0d escaped before it",
               cap_hits, checked_n - cap_hits);
      if (fail_n == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
